[sv/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, record types and helpers of the priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int PRIO_W  = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 12;
    // internal time: last arrival plus up to 64 full bursts
    localparam int TIME_W  = 19;
    localparam int OTIME_W = 17;
    localparam int PIDX_W  = 6;

    localparam logic [OTIME_W-1:0] OTIME_MAX = '1;

    typedef logic [TIME_W-1:0] stime_t;

    // one process record as held in the store
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remain;
        logic               started;
        stime_t             resp;
        stime_t             complete;
    } rec_t;

    // scan result handed from the picker to the control
    typedef struct packed {
        logic             have_pick;
        logic             have_next;
        logic [ARR_W-1:0] next_arr;
    } pick_stat_t;

    // clamp an internal time to the result field range
    function automatic logic [OTIME_W-1:0] sat_time(input stime_t v);
        logic [OTIME_W-1:0] r;
        if (v > stime_t'(OTIME_MAX))
            r = OTIME_MAX;
        else
            r = v[OTIME_W-1:0];
        return r;
    endfunction

endpackage

[sv/pps_in_if.sv]
// ----------------------------------------------------------------------------
// pps_in_if
// Process record channel: valid/ready handshake with record payload.
// ----------------------------------------------------------------------------
interface pps_in_if import pps_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PRIO_W-1:0]  prio;
    logic [ARR_W-1:0]   arrive_time;
    logic [BURST_W-1:0] burst_len;
    logic               is_last;

    modport source (output valid, prio, arrive_time, burst_len, is_last, input ready);
    modport sink   (input valid, prio, arrive_time, burst_len, is_last, output ready);

endinterface

[sv/pps_out_if.sv]
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: valid/ready handshake with per-process statistics.
// ----------------------------------------------------------------------------
interface pps_out_if import pps_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PIDX_W-1:0]  proc_index;
    logic [ARR_W-1:0]   arrive_out;
    logic [BURST_W-1:0] burst_out;
    logic [OTIME_W-1:0] complete_time;
    logic [OTIME_W-1:0] turnaround;
    logic [OTIME_W-1:0] waiting;
    logic [OTIME_W-1:0] response;
    logic               last_result;

    modport source (output valid, proc_index, arrive_out, burst_out, complete_time,
                    turnaround, waiting, response, last_result, input ready);
    modport sink   (input valid, proc_index, arrive_out, burst_out, complete_time,
                    turnaround, waiting, response, last_result, output ready);

endinterface

[sv/preemptive_priority_scheduler_sim_unit.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_sim_unit
// Batch preemptive priority scheduler built around a record memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one process record per transaction (priority, arrival,
//   burst, is_last). Records are taken one per cycle and written to the
//   store; records beyond MAX_PROCS are dropped. A record with is_last set
//   closes the batch, and in_ch.ready stays low until the batch is done.
//   Each scheduling step scans the n stored records: one memory read per
//   record, then a drain state and an update state. A step runs the
//   chosen process up to its completion or up to the next arrival, so a
//   batch takes at most about 2n steps. out_ch returns one transaction per
//   process in load order, each passing through a read, a load and a wait
//   state; last_result marks the final one. A stalled receiver holds the
//   result register and the sequencer waits. After the final result is
//   taken all counts and time return to zero and in_ch.ready rises for the
//   next batch.
//   Reset clears the control state; the record memory needs no clearing.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_sim_unit import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pps_in_if.sink    in_ch,
    pps_out_if.source out_ch
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_TAIL   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_ORD    = 3'd4;
    localparam logic [2:0] ST_OLD    = 3'd5;
    localparam logic [2:0] ST_OWT    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] loaded_reg, loaded_next;
    logic [CNT_W-1:0] finished_reg, finished_next;
    stime_t           time_reg, time_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_data;

    pick_stat_t       stat;
    logic [IDX_W-1:0] pick_idx;
    rec_t             pick_rec;
    logic             pick_clear;

    logic             res_load;
    logic             res_busy;
    logic             res_taken;

    logic               load_fire;
    logic               has_room;
    logic [BURST_W-1:0] burst_in;
    rec_t               load_rec;
    logic               scan_last;
    logic               out_last;

    stime_t             gap;
    logic [BURST_W-1:0] run;
    logic [BURST_W-1:0] remain_new;
    stime_t             time_adv;
    rec_t               wb_rec;

    // input side
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign load_fire   = in_ch.valid && in_ch.ready;
    assign has_room    = (loaded_reg < CNT_W'(MAX_PROCS));
    assign burst_in    = (in_ch.burst_len == '0) ? BURST_W'(1) : in_ch.burst_len;

    always_comb
    begin
        load_rec          = '0;
        load_rec.prio     = in_ch.prio;
        load_rec.arr      = in_ch.arrive_time;
        load_rec.burst    = burst_in;
        load_rec.remain   = burst_in;
        load_rec.started  = 1'b0;
    end

    assign scan_last = ((CNT_W'(scan_idx_reg) + 1'b1) == loaded_reg);
    assign out_last  = ((CNT_W'(out_idx_reg) + 1'b1) == loaded_reg);

    // service span of the chosen process: to completion or next arrival
    assign gap        = stime_t'(stat.next_arr) - time_reg;
    assign run        = (stat.have_next && (gap < stime_t'(pick_rec.remain)))
                        ? gap[BURST_W-1:0] : pick_rec.remain;
    assign remain_new = pick_rec.remain - run;
    assign time_adv   = time_reg + stime_t'(run);

    always_comb
    begin
        wb_rec         = pick_rec;
        wb_rec.remain  = remain_new;
        wb_rec.started = 1'b1;
        if (!pick_rec.started)
            wb_rec.resp = time_reg - stime_t'(pick_rec.arr);
        if (remain_new == '0)
            wb_rec.complete = time_adv;
    end

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = loaded_reg[IDX_W-1:0];
        wr_data = load_rec;
        if (state_reg == ST_LOAD)
        begin
            wr_en = load_fire && has_room;
        end
        else if (state_reg == ST_DECIDE)
        begin
            wr_en   = stat.have_pick;
            wr_addr = pick_idx;
            wr_data = wb_rec;
        end
    end

    assign rd_addr    = (state_reg == ST_SCAN) ? scan_idx_reg : out_idx_reg;
    assign pick_clear = (state_reg == ST_LOAD) || (state_reg == ST_DECIDE);
    assign res_load   = (state_reg == ST_OLD);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        finished_next = finished_reg;
        time_next     = time_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = (state_reg == ST_SCAN);
        cmp_idx_next  = scan_idx_reg;
        out_idx_next  = out_idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    if (has_room)
                        loaded_next = loaded_reg + 1'b1;
                    if (in_ch.is_last)
                    begin
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_TAIL;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            ST_TAIL:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                scan_idx_next = '0;
                state_next    = ST_SCAN;
                if (!stat.have_pick)
                begin
                    // idle gap: jump to the next arrival
                    time_next = stime_t'(stat.next_arr);
                end
                else
                begin
                    time_next = time_adv;
                    if (remain_new == '0)
                    begin
                        finished_next = finished_reg + 1'b1;
                        if ((finished_reg + 1'b1) == loaded_reg)
                        begin
                            out_idx_next = '0;
                            state_next   = ST_ORD;
                        end
                    end
                end
            end
            ST_ORD:
            begin
                state_next = ST_OLD;
            end
            ST_OLD:
            begin
                state_next = ST_OWT;
            end
            ST_OWT:
            begin
                if (res_taken)
                begin
                    if (out_last)
                    begin
                        loaded_next   = '0;
                        finished_next = '0;
                        time_next     = '0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            finished_reg <= '0;
            time_reg     <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            out_idx_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            finished_reg <= finished_next;
            time_reg     <= time_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
    end

    // datapath units
    pps_store #(
        .MAX_PROCS (MAX_PROCS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pps_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (pick_clear),
        .cmp_vld  (cmp_vld_reg),
        .cmp_idx  (cmp_idx_reg),
        .rec      (rd_data),
        .cur_time (time_reg),
        .stat     (stat),
        .pick_idx (pick_idx),
        .pick_rec (pick_rec)
    );

    pps_result #(
        .IDX_W (IDX_W)
    ) u_result (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (res_load),
        .idx    (out_idx_reg),
        .rec    (rd_data),
        .last   (out_last),
        .busy   (res_busy),
        .taken  (res_taken),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    // completions never outrun the batch size
    a_fin_le_load: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg <= loaded_reg)
        else $error("finished count exceeds loaded count");

    // store never overfills
    a_load_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_PROCS))
        else $error("loaded count exceeds capacity");

    // a result is only pending while the sequencer waits for it
    a_out_in_owt: assert property (@(posedge clk) disable iff (!rst_n)
        res_busy |-> (state_reg == ST_OWT))
        else $error("result pending outside output wait");

    // the chosen process always has service left
    a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && stat.have_pick) |-> (pick_rec.remain != '0))
        else $error("picked a finished process");

    // an idle step always has a future arrival to jump to
    a_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !stat.have_pick) |-> stat.have_next)
        else $error("no ready process and no pending arrival");
`endif

endmodule

[sv/pps_store.sv]
// ----------------------------------------------------------------------------
// pps_store
// Process record memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pps_store import pps_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  rec_t             wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output rec_t             rd_data
);

    rec_t mem [MAX_PROCS];
    rec_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/pps_pick.sv]
// ----------------------------------------------------------------------------
// pps_pick
// Scan accumulator: keeps the best ready process and the earliest pending
// arrival over the records streamed out of the store.
// ----------------------------------------------------------------------------
module pps_pick import pps_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             cmp_vld,
    input  logic [IDX_W-1:0] cmp_idx,
    input  rec_t             rec,
    input  stime_t           cur_time,
    output pick_stat_t       stat,
    output logic [IDX_W-1:0] pick_idx,
    output rec_t             pick_rec
);

    logic             have_pick_reg, have_pick_next;
    logic             have_next_reg, have_next_next;
    logic [ARR_W-1:0] next_arr_reg, next_arr_next;
    logic [IDX_W-1:0] pick_idx_reg, pick_idx_next;
    rec_t             pick_rec_reg, pick_rec_next;

    logic live;
    logic arrived;
    logic better;

    // candidate qualification and ordering: priority, then arrival, then index
    assign live    = (rec.remain != '0);
    assign arrived = (stime_t'(rec.arr) <= cur_time);
    assign better  = !have_pick_reg
                  || (rec.prio > pick_rec_reg.prio)
                  || ((rec.prio == pick_rec_reg.prio) && (rec.arr < pick_rec_reg.arr));

    always_comb
    begin
        have_pick_next = have_pick_reg;
        have_next_next = have_next_reg;
        next_arr_next  = next_arr_reg;
        pick_idx_next  = pick_idx_reg;
        pick_rec_next  = pick_rec_reg;
        if (clear)
        begin
            have_pick_next = 1'b0;
            have_next_next = 1'b0;
        end
        else if (cmp_vld && live)
        begin
            if (!arrived)
            begin
                if (!have_next_reg || (rec.arr < next_arr_reg))
                begin
                    have_next_next = 1'b1;
                    next_arr_next  = rec.arr;
                end
            end
            else if (better)
            begin
                have_pick_next = 1'b1;
                pick_idx_next  = cmp_idx;
                pick_rec_next  = rec;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_pick_reg <= 1'b0;
            have_next_reg <= 1'b0;
        end
        else
        begin
            have_pick_reg <= have_pick_next;
            have_next_reg <= have_next_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        next_arr_reg <= next_arr_next;
        pick_idx_reg <= pick_idx_next;
        pick_rec_reg <= pick_rec_next;
    end

    assign stat.have_pick = have_pick_reg;
    assign stat.have_next = have_next_reg;
    assign stat.next_arr  = next_arr_reg;
    assign pick_idx       = pick_idx_reg;
    assign pick_rec       = pick_rec_reg;

endmodule

[sv/pps_result.sv]
// ----------------------------------------------------------------------------
// pps_result
// Result formatter and output register: derives turnaround, waiting and
// response from a finished record and holds the transaction until taken.
// ----------------------------------------------------------------------------
module pps_result import pps_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [IDX_W-1:0] idx,
    input  rec_t             rec,
    input  logic             last,
    output logic             busy,
    output logic             taken,
    pps_out_if.source        out_ch
);

    logic               valid_reg, valid_next;
    logic [PIDX_W-1:0]  pidx_reg;
    logic [ARR_W-1:0]   arr_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [OTIME_W-1:0] ct_reg;
    logic [OTIME_W-1:0] tat_reg;
    logic [OTIME_W-1:0] wt_reg;
    logic [OTIME_W-1:0] resp_reg;
    logic               last_reg;

    stime_t tat;
    stime_t wt;

    // derived statistics
    assign tat = rec.complete - stime_t'(rec.arr);
    assign wt  = tat - stime_t'(rec.burst);

    assign taken = valid_reg && out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pidx_reg  <= PIDX_W'(idx);
            arr_reg   <= rec.arr;
            burst_reg <= rec.burst;
            ct_reg    <= sat_time(rec.complete);
            tat_reg   <= sat_time(tat);
            wt_reg    <= sat_time(wt);
            resp_reg  <= sat_time(rec.resp);
            last_reg  <= last;
        end
    end

    assign busy                 = valid_reg;
    assign out_ch.valid         = valid_reg;
    assign out_ch.proc_index    = pidx_reg;
    assign out_ch.arrive_out    = arr_reg;
    assign out_ch.burst_out     = burst_reg;
    assign out_ch.complete_time = ct_reg;
    assign out_ch.turnaround    = tat_reg;
    assign out_ch.waiting       = wt_reg;
    assign out_ch.response      = resp_reg;
    assign out_ch.last_result   = last_reg;

endmodule
